@@ design/dqb_pkg.sv @@
// DNS query builder package: shared types, register codes and constants.
// No dependencies.
`default_nettype none

package dqb_pkg;

  localparam int unsigned BufferBytesDef = 512;
  localparam int unsigned AddrSpan       = 512;

  localparam int unsigned SlotW = 5;
  localparam logic [SlotW-1:0] SLOT_HDR_FIRST = 5'd0;
  localparam logic [SlotW-1:0] SLOT_CHAR      = 5'd12;
  localparam logic [SlotW-1:0] SLOT_PATCH     = 5'd13;
  localparam logic [SlotW-1:0] SLOT_ROOT      = 5'd14;
  localparam logic [SlotW-1:0] SLOT_TYPE_HI   = 5'd15;
  localparam logic [SlotW-1:0] SLOT_TYPE_LO   = 5'd16;
  localparam logic [SlotW-1:0] SLOT_CLASS_HI  = 5'd17;
  localparam logic [SlotW-1:0] SLOT_LAST      = 5'd18;

  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [9:0] NAME_SLACK = 10'd20;
  localparam logic [9:0] WPOS_RST   = 10'd13;
  localparam logic [9:0] LSTART_RST = 10'd12;
  localparam logic [9:0] WPOS_MAX   = 10'd1023;
  localparam logic [8:0] CCNT_MAX   = 9'd511;

  localparam logic [1:0] CFG_QUERY_ID    = 2'd0;
  localparam logic [1:0] CFG_QUERY_FLAGS = 2'd1;
  localparam logic [1:0] CFG_QUERY_TYPE  = 2'd2;
  localparam logic [1:0] CFG_MAX_BYTES   = 2'd3;

  localparam logic [15:0] QUERY_ID_RST    = 16'd0;
  localparam logic [15:0] QUERY_FLAGS_RST = 16'd256;
  localparam logic [7:0]  QUERY_TYPE_RST  = 8'd1;
  localparam logic [9:0]  MAX_BYTES_RST   = 10'd512;

  typedef struct packed {
    logic [15:0] query_id;
    logic [15:0] query_flags;
    logic [7:0]  query_type;
    logic [9:0]  max_bytes;
  } cfg_t;

  typedef struct packed {
    logic       write_enable;
    logic [8:0] byte_addr;
    logic [7:0] byte_value;
    logic       run_last;
    logic       query_done;
    logic       query_rejected;
    logic [8:0] query_length;
  } res_t;

endpackage

`default_nettype wire

@@ design/dqb_emit.sv @@
// DNS query builder sequencer: item register, slot counter, query state and
// per-slot byte write generation. Uses dqb_pkg.
`default_nettype none

module dqb_emit #(
  parameter int unsigned BUFFER_BYTES = dqb_pkg::BufferBytesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dqb_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    name_char_i,
  input  wire logic          name_last_i,
  input  wire logic          res_ready_i,
  output logic               res_valid_o,
  output dqb_pkg::res_t      res_o
);

  localparam int unsigned CapInt = (BUFFER_BYTES < dqb_pkg::AddrSpan) ?
                                   BUFFER_BYTES : dqb_pkg::AddrSpan;
  localparam logic [9:0] LimCap = 10'(CapInt);

  logic                      itm_vld_q, itm_vld_d;
  logic [7:0]                itm_char_q;
  logic                      itm_last_q;
  logic [dqb_pkg::SlotW-1:0] slot_q, slot_d;
  logic [9:0]                wpos_q, wpos_d;
  logic [9:0]                lstart_q, lstart_d;
  logic [7:0]                llen_q, llen_d;
  logic [8:0]                ccnt_q, ccnt_d;

  logic        fire, in_rdy, in_acc, is_dot, run_last;
  logic [9:0]  lim;
  logic [10:0] pos;
  logic [7:0]  val;
  logic [2:0]  offs;
  logic        use_lstart;
  logic        rejected;

  assign lim      = (cfg_i.max_bytes < LimCap) ? cfg_i.max_bytes : LimCap;
  assign is_dot   = (itm_char_q == dqb_pkg::DOT_CHAR);
  assign fire     = itm_vld_q & res_ready_i;
  assign run_last = (slot_q == dqb_pkg::SLOT_LAST) ||
                    ((slot_q == dqb_pkg::SLOT_CHAR) && !itm_last_q);
  assign in_rdy   = !itm_vld_q || (fire && run_last);
  assign in_stall_o = !in_rdy;
  assign in_acc   = in_valid_i & in_rdy;
  assign rejected = (lim <= ({1'b0, ccnt_q} + dqb_pkg::NAME_SLACK));

  always_comb begin
    offs       = 3'd0;
    use_lstart = 1'b0;
    val        = 8'd0;
    pos        = {6'd0, slot_q};
    case (slot_q)
      dqb_pkg::SLOT_CHAR: begin
        if (is_dot) begin
          use_lstart = 1'b1;
          val        = llen_q;
        end else begin
          val = itm_char_q;
        end
      end
      dqb_pkg::SLOT_PATCH: begin
        use_lstart = 1'b1;
        val        = llen_q;
      end
      dqb_pkg::SLOT_ROOT:     offs = 3'd0;
      dqb_pkg::SLOT_TYPE_HI:  offs = 3'd1;
      dqb_pkg::SLOT_TYPE_LO: begin
        offs = 3'd2;
        val  = cfg_i.query_type;
      end
      dqb_pkg::SLOT_CLASS_HI: offs = 3'd3;
      dqb_pkg::SLOT_LAST: begin
        offs = 3'd4;
        val  = 8'd1;
      end
      default: begin
        case (slot_q[3:0])
          4'd0:    val = cfg_i.query_id[15:8];
          4'd1:    val = cfg_i.query_id[7:0];
          4'd2:    val = cfg_i.query_flags[15:8];
          4'd3:    val = cfg_i.query_flags[7:0];
          4'd5:    val = 8'd1;
          default: val = 8'd0;
        endcase
      end
    endcase
    if (slot_q >= dqb_pkg::SLOT_CHAR) begin
      pos = use_lstart ? {1'b0, lstart_q} : ({1'b0, wpos_q} + {8'd0, offs});
    end
  end

  always_comb begin
    res_valid_o          = itm_vld_q;
    res_o.write_enable   = (pos < {1'b0, lim});
    res_o.byte_addr      = pos[8:0];
    res_o.byte_value     = val;
    res_o.run_last       = run_last;
    res_o.query_done     = (slot_q == dqb_pkg::SLOT_LAST);
    res_o.query_rejected = (slot_q == dqb_pkg::SLOT_LAST) && rejected;
    res_o.query_length   = ((slot_q == dqb_pkg::SLOT_LAST) && !rejected) ?
                           (pos[8:0] + 9'd1) : 9'd0;
  end

  always_comb begin
    itm_vld_d = in_acc ? 1'b1 : ((fire && run_last) ? 1'b0 : itm_vld_q);
    slot_d    = slot_q;
    wpos_d    = wpos_q;
    lstart_d  = lstart_q;
    llen_d    = llen_q;
    ccnt_d    = ccnt_q;
    if (fire) begin
      if (slot_q == dqb_pkg::SLOT_LAST) begin
        slot_d   = dqb_pkg::SLOT_HDR_FIRST;
        wpos_d   = dqb_pkg::WPOS_RST;
        lstart_d = dqb_pkg::LSTART_RST;
        llen_d   = 8'd0;
        ccnt_d   = 9'd0;
      end else begin
        slot_d = run_last ? dqb_pkg::SLOT_CHAR : (slot_q + 5'd1);
        if (slot_q == dqb_pkg::SLOT_CHAR) begin
          if (ccnt_q != dqb_pkg::CCNT_MAX) ccnt_d = ccnt_q + 9'd1;
          if (wpos_q != dqb_pkg::WPOS_MAX) wpos_d = wpos_q + 10'd1;
          if (is_dot) begin
            lstart_d = wpos_q;
            llen_d   = 8'd0;
          end else begin
            llen_d = llen_q + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_vld_q <= 1'b0;
      slot_q    <= dqb_pkg::SLOT_HDR_FIRST;
      wpos_q    <= dqb_pkg::WPOS_RST;
      lstart_q  <= dqb_pkg::LSTART_RST;
      llen_q    <= 8'd0;
      ccnt_q    <= 9'd0;
    end else begin
      itm_vld_q <= itm_vld_d;
      slot_q    <= slot_d;
      wpos_q    <= wpos_d;
      lstart_q  <= lstart_d;
      llen_q    <= llen_d;
      ccnt_q    <= ccnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      itm_char_q <= name_char_i;
      itm_last_q <= name_last_i;
    end
  end

`ifndef SYNTH
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= dqb_pkg::SLOT_LAST)
    else $error("slot counter out of range");
  a_hdr_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q != dqb_pkg::SLOT_HDR_FIRST && slot_q != dqb_pkg::SLOT_CHAR) |-> itm_vld_q)
    else $error("mid-item slot without a held item");
  a_label_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lstart_q < wpos_q || wpos_q == dqb_pkg::WPOS_MAX)
    else $error("label start past write position");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && slot_q == dqb_pkg::SLOT_LAST) |=>
      (slot_q == dqb_pkg::SLOT_HDR_FIRST && wpos_q == dqb_pkg::WPOS_RST && ccnt_q == 9'd0))
    else $error("query state not cleared after final write");
`endif

endmodule

`default_nettype wire

@@ design/dqb_out.sv @@
// DNS query builder result register: holds one byte write for the receiver.
// Uses dqb_pkg.
`default_nettype none

module dqb_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  output logic               res_ready_o,
  input  wire dqb_pkg::res_t res_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dqb_pkg::res_t      out_o
);

  logic          vld_q, vld_d;
  dqb_pkg::res_t res_q;

  assign res_ready_o = !vld_q || !out_stall_i;
  assign vld_d       = res_valid_i ? 1'b1 : (out_stall_i & vld_q);
  assign out_valid_o = vld_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_ready_o) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && out_stall_i) |=> (vld_q && $stable(res_q)))
    else $error("stalled item changed");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res_q.query_done) |-> res_q.run_last)
    else $error("final write not marked last");
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !res_q.query_done) |-> (res_q.query_length == 9'd0 && !res_q.query_rejected))
    else $error("length on a non-final write");
`endif

endmodule

`default_nettype wire

@@ design/dns_query_builder.sv @@
// DNS query builder top level: configuration registers, sequencer and
// result register. Uses dqb_pkg, dqb_emit, dqb_out.
//
// Usage: the host name enters one character per item on the input channel
// (name_char_i, name_last_i; in_valid_i / in_stall_o). Each item yields one
// or more byte writes on the output channel (out_valid_o / out_stall_i),
// one per cycle when not stalled, run_last_o on the last write of an item.
// The first character of a query yields the 12 header writes plus its own
// write; a plain character or dot yields one write; the last character adds
// six writes (label length patch, root zero, type and class), the final one
// with query_done_o, query_rejected_o and query_length_o.
// The first write passes the item register, then the result register.
// Throughput: one item per cycle while no header or trailer is being sent
// and the receiver does not stall; a new item is taken as the last write of
// the current one enters the single result register from the slot sequencer.
// Reset clears the query state and loads the register defaults; no clearing
// pass is needed. When the receiver stalls, the result register holds and
// the sequencer and input channel stall behind it. The user writes registers
// via cfg_we_i / cfg_idx_i / cfg_wdata_i only while idle (not enforced).
`default_nettype none

module dns_query_builder #(
  parameter int unsigned BUFFER_BYTES = dqb_pkg::BufferBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  name_char_i,
  input  wire logic        name_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             write_enable_o,
  output logic [8:0]       byte_addr_o,
  output logic [7:0]       byte_value_o,
  output logic             run_last_o,
  output logic             query_done_o,
  output logic             query_rejected_o,
  output logic [8:0]       query_length_o
);

  dqb_pkg::cfg_t cfg_q;
  dqb_pkg::res_t res, out;
  logic          res_valid, res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.query_id    <= dqb_pkg::QUERY_ID_RST;
      cfg_q.query_flags <= dqb_pkg::QUERY_FLAGS_RST;
      cfg_q.query_type  <= dqb_pkg::QUERY_TYPE_RST;
      cfg_q.max_bytes   <= dqb_pkg::MAX_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dqb_pkg::CFG_QUERY_ID:    cfg_q.query_id    <= cfg_wdata_i;
        dqb_pkg::CFG_QUERY_FLAGS: cfg_q.query_flags <= cfg_wdata_i;
        dqb_pkg::CFG_QUERY_TYPE:  cfg_q.query_type  <= cfg_wdata_i[7:0];
        dqb_pkg::CFG_MAX_BYTES:   cfg_q.max_bytes   <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  dqb_emit #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .name_char_i(name_char_i),
    .name_last_i(name_last_i),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  dqb_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (res),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out)
  );

  assign write_enable_o   = out.write_enable;
  assign byte_addr_o      = out.byte_addr;
  assign byte_value_o     = out.byte_value;
  assign run_last_o       = out.run_last;
  assign query_done_o     = out.query_done;
  assign query_rejected_o = out.query_rejected;
  assign query_length_o   = out.query_length;

endmodule

`default_nettype wire
